[rtl/core/irc_line_tokenizer_macros.svh]
// Assertion helpers used by the tokenizer top level.
`ifndef IRC_LINE_TOKENIZER_MACROS_SVH
`define IRC_LINE_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IRCLT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IRCLT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/irclt_pkg.sv]
package irclt_pkg;

    // Parameter defaults.
    localparam int HOLD_DEPTH_DEF = 16;
    localparam int MAX_PARAMS_DEF = 15;

    // Command queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPW    = 2;

    // Port widths.
    localparam int TDATA_W = 16;
    localparam int TUSER_W = 6;
    localparam int PNUM_W  = 4;

    // Characters the parser reacts to.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Token kinds.
    localparam logic [1:0] KIND_PREFIX   = 2'd0;
    localparam logic [1:0] KIND_CMD      = 2'd1;
    localparam logic [1:0] KIND_MIDDLE   = 2'd2;
    localparam logic [1:0] KIND_TRAILING = 2'd3;

    // One queued command: feed a byte to the parser, close the message, or both.
    typedef struct packed {
        logic [7:0] data;
        logic       feed;
        logic       close;
    } op_t;

endpackage

[rtl/core/irclt_front.sv]
module irclt_front #(
    parameter int HOLD_DEPTH = irclt_pkg::HOLD_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // in_byte
    input  logic            s_tlast,   // in_last
    input  logic            q_full,
    output logic            q_push,
    output irclt_pkg::op_t  q_op
);
    import irclt_pkg::*;

    localparam int IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(HOLD_DEPTH + 1);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_RELEASE = 2'd1;
    localparam logic [1:0] ST_FINISH  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] held_cnt_reg, held_cnt_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          dv_reg, dv_next;
    logic [7:0]    pend_byte_reg, pend_byte_next;
    logic          pend_last_reg, pend_last_next;
    logic          rd_lf_reg;
    logic          held_mem [HOLD_DEPTH];

    logic [7:0] cur_byte;
    logic       cur_last;
    logic       cur_crlf;
    logic       hold_full;
    logic       accept;
    logic       need_rel;
    logic       do_finish;
    logic       rd_en;
    logic       push_rel;
    logic       mem_we;

    assign s_tready  = (state_reg == ST_IDLE) && !q_full;
    assign accept    = s_tvalid && s_tready;
    assign cur_byte  = (state_reg == ST_IDLE) ? s_tdata : pend_byte_reg;
    assign cur_last  = (state_reg == ST_IDLE) ? s_tlast : pend_last_reg;
    assign cur_crlf  = (cur_byte == CH_CR) || (cur_byte == CH_LF);
    assign hold_full = (held_cnt_reg == CW'(HOLD_DEPTH));
    assign need_rel  = cur_crlf ? hold_full : (held_cnt_reg != '0);

    // Sequencer: hold CR/LF bits, release the held run as bytes, then queue the beat.
    always_comb begin
        state_next     = state_reg;
        held_cnt_next  = held_cnt_reg;
        rd_idx_next    = rd_idx_reg;
        dv_next        = dv_reg;
        pend_byte_next = pend_byte_reg;
        pend_last_next = pend_last_reg;
        do_finish      = 1'b0;
        rd_en          = 1'b0;
        push_rel       = 1'b0;
        mem_we         = 1'b0;
        q_push         = 1'b0;
        q_op           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (need_rel) begin
                        pend_byte_next = s_tdata;
                        pend_last_next = s_tlast;
                        rd_idx_next    = '0;
                        dv_next        = 1'b0;
                        state_next     = ST_RELEASE;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
            ST_RELEASE: begin
                // One held bit is read ahead; it goes out as CR or LF when the queue has room.
                push_rel = dv_reg && !q_full;
                rd_en    = (!dv_reg || push_rel) && (rd_idx_reg < held_cnt_reg);
                if (push_rel) begin
                    q_push     = 1'b1;
                    q_op.data  = rd_lf_reg ? CH_LF : CH_CR;
                    q_op.feed  = 1'b1;
                    q_op.close = 1'b0;
                end
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                    dv_next     = 1'b1;
                end else if (push_rel) begin
                    dv_next = 1'b0;
                end
                if (!rd_en && (!dv_reg || push_rel)) begin
                    held_cnt_next = '0;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!q_full) begin
                    do_finish  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // The beat itself: hold a CR/LF, or queue the byte; close the message on last.
        if (do_finish) begin
            if (cur_crlf) begin
                mem_we        = 1'b1;
                held_cnt_next = held_cnt_reg + CW'(1);
                if (cur_last) begin
                    q_push        = 1'b1;
                    q_op.data     = 8'd0;
                    q_op.feed     = 1'b0;
                    q_op.close    = 1'b1;
                    held_cnt_next = '0;
                end
            end else begin
                q_push        = 1'b1;
                q_op.data     = cur_byte;
                q_op.feed     = 1'b1;
                q_op.close    = cur_last;
                held_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            held_cnt_reg <= '0;
            rd_idx_reg   <= '0;
            dv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            held_cnt_reg <= held_cnt_next;
            rd_idx_reg   <= rd_idx_next;
            dv_reg       <= dv_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_byte_reg <= pend_byte_next;
        pend_last_reg <= pend_last_next;
    end

    // Held-run bit store: 1 for LF, 0 for CR.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            held_mem[held_cnt_reg[IW-1:0]] <= (cur_byte == CH_LF);
        end
        if (rd_en) begin
            rd_lf_reg <= held_mem[rd_idx_reg[IW-1:0]];
        end
    end

endmodule

[rtl/core/irclt_fifo.sv]
module irclt_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  irclt_pkg::op_t push_op,
    output logic           full,
    output logic           head_valid,
    output irclt_pkg::op_t head_op,
    input  logic           pop
);
    import irclt_pkg::*;

    op_t            slot_reg [QDEPTH];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPW:0]   cnt_reg, cnt_next;
    logic           do_push;
    logic           do_pop;

    assign full       = (cnt_reg == (QPW+1)'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + (QPW+1)'(1);
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - (QPW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[rtl/core/irclt_back.sv]
module irclt_back #(
    parameter int MAX_PARAMS = irclt_pkg::MAX_PARAMS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  irclt_pkg::op_t                 q_head,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [irclt_pkg::TDATA_W-1:0]  m_tdata,
    output logic [irclt_pkg::TUSER_W-1:0]  m_tuser,
    output logic                           m_tlast
);
    import irclt_pkg::*;

    localparam logic [2:0] PH_START     = 3'd0;
    localparam logic [2:0] PH_PREFIX    = 3'd1;
    localparam logic [2:0] PH_GAP_CMD   = 3'd2;
    localparam logic [2:0] PH_CMD       = 3'd3;
    localparam logic [2:0] PH_GAP_PARAM = 3'd4;
    localparam logic [2:0] PH_MIDDLE    = 3'd5;
    localparam logic [2:0] PH_TRAILING  = 3'd6;

    logic [2:0]         phase_reg, phase_next;
    logic [PNUM_W-1:0]  pc_reg, pc_next;
    logic               ovf_reg, ovf_next;
    logic               fresh_reg, fresh_next;
    logic               fed_reg, fed_next;
    logic               vld_reg, vld_next;
    logic [TDATA_W-1:0] data_reg, data_next;
    logic [TUSER_W-1:0] user_reg, user_next;
    logic               last_reg, last_next;

    logic               advance;
    logic               emit;
    logic [1:0]         kind;
    logic               start;
    logic [7:0]         b;
    logic [PNUM_W-1:0]  pnum;

    assign advance  = q_valid && (!vld_reg || m_tready);
    assign b        = q_head.data;
    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    // Token parser for one byte.
    always_comb begin
        phase_next = phase_reg;
        pc_next    = pc_reg;
        ovf_next   = ovf_reg;
        fresh_next = fresh_reg;
        emit       = 1'b0;
        kind       = KIND_PREFIX;
        start      = 1'b0;

        unique case (phase_reg) inside
            PH_START, PH_GAP_CMD: begin
                if (b == CH_SPACE) begin
                    phase_next = PH_GAP_CMD;
                end else if (b == CH_COLON && phase_reg == PH_START) begin
                    phase_next = PH_PREFIX;
                    fresh_next = 1'b1;
                end else begin
                    emit       = 1'b1;
                    kind       = KIND_CMD;
                    start      = 1'b1;
                    phase_next = PH_CMD;
                end
            end
            PH_PREFIX: begin
                fresh_next = 1'b0;
                if (b == CH_SPACE) begin
                    phase_next = PH_GAP_CMD;
                end else begin
                    emit  = 1'b1;
                    kind  = KIND_PREFIX;
                    start = fresh_reg;
                end
            end
            PH_CMD: begin
                if (b == CH_SPACE) begin
                    phase_next = PH_GAP_PARAM;
                end else begin
                    emit = 1'b1;
                    kind = KIND_CMD;
                end
            end
            PH_GAP_PARAM: begin
                if (b != CH_SPACE) begin
                    // A new parameter begins; the count saturates at the bound.
                    if (pc_reg < PNUM_W'(MAX_PARAMS)) begin
                        pc_next = pc_reg + PNUM_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (b == CH_COLON) begin
                        phase_next = PH_TRAILING;
                        fresh_next = 1'b1;
                    end else begin
                        emit       = 1'b1;
                        kind       = KIND_MIDDLE;
                        start      = 1'b1;
                        phase_next = PH_MIDDLE;
                    end
                end
            end
            PH_MIDDLE: begin
                if (b == CH_SPACE) begin
                    phase_next = PH_GAP_PARAM;
                end else begin
                    emit = 1'b1;
                    kind = KIND_MIDDLE;
                end
            end
            PH_TRAILING: begin
                emit       = 1'b1;
                kind       = KIND_TRAILING;
                start      = fresh_reg;
                fresh_next = 1'b0;
            end
            default: begin
                phase_next = PH_START;
            end
        endcase

        // Parameter bytes carry the index of the newest parameter.
        if (kind == KIND_MIDDLE || kind == KIND_TRAILING) begin
            pnum = (pc_next == '0) ? '0 : pc_next - PNUM_W'(1);
        end else begin
            pnum = '0;
        end
    end

    // Output register and command retirement.
    always_comb begin
        vld_next  = vld_reg && !m_tready;
        data_next = data_reg;
        user_next = user_reg;
        last_next = last_reg;
        fed_next  = fed_reg;
        q_pop     = 1'b0;

        if (advance) begin
            if (q_head.feed && !fed_reg) begin
                vld_next  = emit;
                data_next = TDATA_W'({pnum, b});
                user_next = {1'b0, 1'b0, start, kind, 1'b1};
                last_next = 1'b0;
                if (q_head.close) begin
                    fed_next = 1'b1;
                end else begin
                    q_pop = 1'b1;
                end
            end else begin
                // End marker: parameters seen, unclosed prefix, overflow.
                vld_next  = 1'b1;
                data_next = TDATA_W'({pc_reg, 8'd0});
                user_next = {ovf_reg, (phase_reg == PH_PREFIX), 1'b0, KIND_PREFIX, 1'b0};
                last_next = 1'b1;
                fed_next  = 1'b0;
                q_pop     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            pc_reg    <= '0;
            ovf_reg   <= 1'b0;
            fresh_reg <= 1'b0;
            fed_reg   <= 1'b0;
            vld_reg   <= 1'b0;
        end else begin
            vld_reg <= vld_next;
            fed_reg <= fed_next;
            if (advance) begin
                if (q_head.feed && !fed_reg) begin
                    phase_reg <= phase_next;
                    pc_reg    <= pc_next;
                    ovf_reg   <= ovf_next;
                    fresh_reg <= fresh_next;
                end else begin
                    phase_reg <= PH_START;
                    pc_reg    <= '0;
                    ovf_reg   <= 1'b0;
                    fresh_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

endmodule

[rtl/core/irc_line_tokenizer.sv]
// Path: a content byte is registered in the command queue and then in the output register.
// Throughput: one beat per cycle while the queue has room and no held run is released; the back
// end sends a closing content beat as its byte, then its end marker. Releasing a held CR/LF run
// stalls input: one bit read ahead, held bytes queued via the single read port, then the beat.
// Reset: aresetn is synchronous, active low; it empties the queue and output register,
// returns the parser to line start and leaves the hold store uncleared.
module irc_line_tokenizer #(
    parameter int HOLD_DEPTH = irclt_pkg::HOLD_DEPTH_DEF,
    parameter int MAX_PARAMS = irclt_pkg::MAX_PARAMS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // in_byte
    input  logic                          s_tlast,   // in_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [irclt_pkg::TDATA_W-1:0] m_tdata,   // out_byte, param_number, zero fill
    output logic [irclt_pkg::TUSER_W-1:0] m_tuser,   // has_byte, token_kind, token_start,
                                                     // malformed, param_overflow
    output logic                          m_tlast    // end_of_message
);
    import irclt_pkg::*;

`include "irc_line_tokenizer_macros.svh"

    logic q_full;
    logic q_push;
    op_t  q_op;
    logic q_valid;
    op_t  q_head;
    logic q_pop;

    // Front: holds CR/LF runs and turns beats into parser commands.
    irclt_front #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_op    (q_op)
    );

    // Command queue.
    irclt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_op   (q_op),
        .full      (q_full),
        .head_valid(q_valid),
        .head_op   (q_head),
        .pop       (q_pop)
    );

    // Back: token parser and output register.
    irclt_back #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // The front never pushes into a full queue.
    `IRCLT_ASSERT_NOW(a_no_q_overflow, aclk, aresetn, q_push, !q_full, "queue overflow")

    // Content beats carry a byte and never carry end-marker flags.
    `IRCLT_ASSERT_NOW(a_content_flags, aclk, aresetn, m_tvalid && !m_tlast,
        m_tuser[0] && !m_tuser[4] && !m_tuser[5], "content beat with marker flags")

    // Prefix and command bytes carry parameter index zero.
    `IRCLT_ASSERT_NOW(a_prefix_cmd_index, aclk, aresetn,
        m_tvalid && !m_tlast && !m_tuser[2], m_tdata[11:8] == 4'd0,
        "nonzero index on prefix or command byte")

endmodule
